// ===== rtl/core/lrfd_pkg.sv =====
// Shared types and constants for the line run-length frame decoder.
// No dependencies; imported by every module of the block.
package lrfd_pkg;

   localparam int CODE_W   = 8;
   localparam int COUNT_W  = 8;
   localparam int CFG_W    = 10;
   localparam int LINES_W  = 16;
   localparam int LIMIT_W  = 2 * CFG_W;
   localparam int OADDR_W  = 16;

   // configuration register indexes
   localparam logic REG_LINE_WIDTH = 1'b0;
   localparam logic REG_KEY_LINES  = 1'b1;

   typedef struct packed {
      logic [CODE_W-1:0] code_byte;
      logic              frame_start;
      logic              mode;
   } item_type;

   typedef struct packed {
      logic [CFG_W-1:0]   line_width;
      logic [CFG_W-1:0]   key_lines;
      logic [LIMIT_W-1:0] area_limit;
   } cfg_type;

   typedef struct packed {
      logic               has_result;
      logic [OADDR_W-1:0] write_addr;
      logic [COUNT_W-1:0] write_count;
      logic [CODE_W-1:0]  pixel_value;
      logic               frame_done;
      logic               outside;
   } result_type;

endpackage

// ===== rtl/core/lrfd_cfg.sv =====
// Configuration registers and the registered frame area (width times lines).
// Depends on lrfd_pkg.
module lrfd_cfg (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic                     csr_index,
   input  logic [lrfd_pkg::CFG_W-1:0] csr_write_data,
   output lrfd_pkg::cfg_type        cfg
);
   import lrfd_pkg::*;

   logic [CFG_W-1:0]   line_width_ff, line_width_in;
   logic [CFG_W-1:0]   key_lines_ff, key_lines_in;
   logic [LIMIT_W-1:0] area_limit_ff, area_limit_in;

   always_comb begin
      line_width_in = line_width_ff;
      key_lines_in  = key_lines_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_LINE_WIDTH: line_width_in = csr_write_data;
            REG_KEY_LINES:  key_lines_in  = csr_write_data;
            default:        ;
         endcase
      end
      // area follows the register values at the same edge
      area_limit_in = LIMIT_W'(line_width_in) * LIMIT_W'(key_lines_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= CFG_W'(320);
         key_lines_ff  <= CFG_W'(200);
         area_limit_ff <= LIMIT_W'(320 * 200);
      end else begin
         line_width_ff <= line_width_in;
         key_lines_ff  <= key_lines_in;
         area_limit_ff <= area_limit_in;
      end
   end

   assign cfg.line_width = line_width_ff;
   assign cfg.key_lines  = key_lines_ff;
   assign cfg.area_limit = area_limit_ff;

endmodule

// ===== rtl/core/lrfd_parse.sv =====
// Stream parser: header, line, entry and run state, one code byte per fire.
// Depends on lrfd_pkg; produces the result word for the output register.
module lrfd_parse #(
   parameter int ADDR_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  lrfd_pkg::item_type   item,
   input  lrfd_pkg::cfg_type    cfg,
   output lrfd_pkg::result_type result
);
   import lrfd_pkg::*;

   localparam int PROD_W = LINES_W + CFG_W;
   localparam int EXT_W  = (ADDR_BITS > OADDR_W) ? ADDR_BITS : OADDR_W;
   localparam int SUM_W  = ADDR_BITS + 1;
   localparam int CMP_W  = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;

   typedef enum logic [9:0] {
      PH_IDLE    = 10'b00_0000_0001,
      PH_HDR0    = 10'b00_0000_0010,
      PH_HDR1    = 10'b00_0000_0100,
      PH_HDR2    = 10'b00_0000_1000,
      PH_HDR3    = 10'b00_0001_0000,
      PH_COUNT   = 10'b00_0010_0000,
      PH_SKIP    = 10'b00_0100_0000,
      PH_FLAG    = 10'b00_1000_0000,
      PH_LIT     = 10'b01_0000_0000,
      PH_FILLVAL = 10'b10_0000_0000
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic                   is_delta_ff, is_delta_in;
   logic [LINES_W-1:0]     lines_left_ff, lines_left_in;
   logic [COUNT_W-1:0]     entries_left_ff, entries_left_in;
   logic [COUNT_W-1:0]     literals_left_ff, literals_left_in;
   logic [ADDR_BITS-1:0]   write_pointer_ff, write_pointer_in;
   logic [ADDR_BITS-1:0]   line_begin_ff, line_begin_in;
   logic [CODE_W-1:0]      header_low_ff, header_low_in;
   logic [COUNT_W-1:0]     fill_count_ff, fill_count_in;

   logic                   done_now;
   logic                   have_write;
   logic [ADDR_BITS-1:0]   waddr;
   logic [COUNT_W-1:0]     wcount;
   logic [EXT_W-1:0]       waddr_ext;
   logic [CMP_W-1:0]       end_addr;

   always_comb begin
      logic [CODE_W-1:0]  b;
      logic               skip_byte;
      logic               entry_end;
      logic               line_end;
      logic               neg;
      logic [COUNT_W-1:0] mag;
      logic               literal;
      logic [PROD_W-1:0]  prod;

      b          = item.code_byte;
      skip_byte  = 1'b0;
      entry_end  = 1'b0;
      line_end   = 1'b0;
      neg        = b[CODE_W-1];
      mag        = neg ? (COUNT_W'(0) - b) : b;
      literal    = 1'b0;
      prod       = {b, header_low_ff} * PROD_W'(cfg.line_width);
      done_now   = 1'b0;
      have_write = 1'b0;
      waddr      = '0;
      wcount     = '0;

      phase_in         = phase_ff;
      is_delta_in      = is_delta_ff;
      lines_left_in    = lines_left_ff;
      entries_left_in  = entries_left_ff;
      literals_left_in = literals_left_ff;
      write_pointer_in = write_pointer_ff;
      line_begin_in    = line_begin_ff;
      header_low_in    = header_low_ff;
      fill_count_in    = fill_count_ff;

      // frame start resets the frame state, then the byte parses as usual unless key_lines is zero
      if (item.frame_start) begin
         is_delta_in      = item.mode;
         entries_left_in  = '0;
         literals_left_in = '0;
         fill_count_in    = '0;
         header_low_in    = '0;
         write_pointer_in = '0;
         line_begin_in    = '0;
         if (item.mode) begin
            lines_left_in = '0;
            phase_in      = PH_HDR0;
         end else begin
            lines_left_in = LINES_W'(cfg.key_lines);
            if (cfg.key_lines == '0) begin
               phase_in  = PH_IDLE;
               done_now  = 1'b1;
               skip_byte = 1'b1;
            end else begin
               phase_in = PH_COUNT;
            end
         end
      end

      if (!skip_byte) begin
         unique case (phase_in)
            PH_HDR0: begin
               header_low_in = b;
               phase_in      = PH_HDR1;
            end
            PH_HDR1: begin
               line_begin_in    = prod[ADDR_BITS-1:0];
               write_pointer_in = prod[ADDR_BITS-1:0];
               phase_in         = PH_HDR2;
            end
            PH_HDR2: begin
               header_low_in = b;
               phase_in      = PH_HDR3;
            end
            PH_HDR3: begin
               // line count zero or negative ends the frame here
               if (neg || (b == '0 && header_low_in == '0)) begin
                  lines_left_in = '0;
                  phase_in      = PH_IDLE;
                  done_now      = 1'b1;
               end else begin
                  lines_left_in = {b, header_low_in};
                  phase_in      = PH_COUNT;
               end
            end
            PH_COUNT: begin
               entries_left_in = b;
               if (b == '0) line_end = 1'b1;
               else phase_in = is_delta_in ? PH_SKIP : PH_FLAG;
            end
            PH_SKIP: begin
               write_pointer_in = write_pointer_in + ADDR_BITS'(b);
               phase_in         = PH_FLAG;
            end
            PH_FLAG: begin
               literal = is_delta_in ? (!neg && b != '0) : neg;
               if (literal) begin
                  literals_left_in = mag;
                  phase_in         = PH_LIT;
               end else begin
                  fill_count_in = mag;
                  phase_in      = PH_FILLVAL;
               end
            end
            PH_LIT: begin
               have_write       = 1'b1;
               waddr            = write_pointer_in;
               wcount           = COUNT_W'(1);
               write_pointer_in = write_pointer_in + ADDR_BITS'(1);
               literals_left_in = literals_left_in - COUNT_W'(1);
               if (literals_left_in == '0) entry_end = 1'b1;
            end
            PH_FILLVAL: begin
               if (fill_count_in != '0) begin
                  have_write       = 1'b1;
                  waddr            = write_pointer_in;
                  wcount           = fill_count_in;
                  write_pointer_in = write_pointer_in + ADDR_BITS'(fill_count_in);
               end
               entry_end = 1'b1;
            end
            default: ;
         endcase
      end

      if (entry_end) begin
         entries_left_in = entries_left_in - COUNT_W'(1);
         if (entries_left_in == '0) line_end = 1'b1;
         else phase_in = is_delta_in ? PH_SKIP : PH_FLAG;
      end

      if (line_end) begin
         line_begin_in    = line_begin_in + ADDR_BITS'(cfg.line_width);
         write_pointer_in = line_begin_in;
         lines_left_in    = lines_left_in - LINES_W'(1);
         if (lines_left_in == '0) begin
            phase_in = PH_IDLE;
            done_now = 1'b1;
         end else begin
            phase_in = PH_COUNT;
         end
      end
   end

   assign waddr_ext = EXT_W'(waddr);
   assign end_addr  = CMP_W'(waddr) + CMP_W'(wcount);

   assign result.has_result  = have_write || done_now;
   assign result.write_addr  = waddr_ext[OADDR_W-1:0];
   assign result.write_count = wcount;
   assign result.pixel_value = have_write ? item.code_byte : '0;
   assign result.frame_done  = done_now;
   assign result.outside     = have_write && (end_addr > CMP_W'(cfg.area_limit));

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         is_delta_ff      <= 1'b0;
         lines_left_ff    <= '0;
         entries_left_ff  <= '0;
         literals_left_ff <= '0;
         write_pointer_ff <= '0;
         line_begin_ff    <= '0;
         header_low_ff    <= '0;
         fill_count_ff    <= '0;
      end else if (fire) begin
         phase_ff         <= phase_in;
         is_delta_ff      <= is_delta_in;
         lines_left_ff    <= lines_left_in;
         entries_left_ff  <= entries_left_in;
         literals_left_ff <= literals_left_in;
         write_pointer_ff <= write_pointer_in;
         line_begin_ff    <= line_begin_in;
         header_low_ff    <= header_low_in;
         fill_count_ff    <= fill_count_in;
      end
   end

endmodule

// ===== rtl/core/line_rle_frame_decoder_unit.sv =====
// Line run-length frame decoder, top level. Depends on lrfd_pkg, lrfd_cfg, lrfd_parse.
// Instantiates the configuration registers and the parser between an input
// register and a result register.
//
// The decoder takes one compressed frame byte per word and turns it into
// frame-buffer write words (start address, count, value). It sustains one
// byte per clock while rsp_stall does not hold a waiting result: a byte is
// captured in the input register, parsed by the combinational parser state
// update once the output register can take its result, and its result (if
// any) is loaded into the output register at the end of that cycle. The
// input register keeps taking bytes while a finished result waits in the
// output register; once both hold words and rsp_stall is high, req_stall
// rises. Bytes that produce no write (headers, counts, skips, flags) give no
// rsp_ word except when they end a frame, in which case a word with count 0
// and frame_done set is sent. line_width and key_lines may be written only
// while the decoder is idle; there is no clearing pass after reset.
module line_rle_frame_decoder_unit #(
   parameter int ADDR_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   // compressed byte input
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [lrfd_pkg::CODE_W-1:0]  req_code_byte,
   input  logic                         req_frame_start,
   input  logic                         req_mode,
   // write command output
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [lrfd_pkg::OADDR_W-1:0] rsp_write_addr,
   output logic [lrfd_pkg::COUNT_W-1:0] rsp_write_count,
   output logic [lrfd_pkg::CODE_W-1:0]  rsp_pixel_value,
   output logic                         rsp_frame_done,
   output logic                         rsp_outside,
   // configuration writes
   input  logic                         csr_write_enable,
   input  logic                         csr_index,
   input  logic [lrfd_pkg::CFG_W-1:0]   csr_write_data
);
   import lrfd_pkg::*;

   cfg_type    cfg;
   result_type result;

   // input register
   logic       stage_valid_ff, stage_valid_in;
   item_type   stage_item_ff;
   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_word_ff;

   logic       advance;   // parser may consume the staged byte
   logic       fire;
   logic       req_accept;

   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign fire       = stage_valid_ff && advance;
   assign req_stall  = stage_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_accept) stage_valid_in = 1'b1;
      else if (advance) stage_valid_in = 1'b0;

      // load a new result, else drop a taken word, else hold
      if (fire && result.has_result) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      if (req_accept) begin
         stage_item_ff.code_byte   <= req_code_byte;
         stage_item_ff.frame_start <= req_frame_start;
         stage_item_ff.mode        <= req_mode;
      end
      if (fire && result.has_result) rsp_word_ff <= result;
   end

   lrfd_cfg u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   lrfd_parse #(
      .ADDR_BITS (ADDR_BITS)
   ) u_parse (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (stage_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_write_addr  = rsp_word_ff.write_addr;
   assign rsp_write_count = rsp_word_ff.write_count;
   assign rsp_pixel_value = rsp_word_ff.pixel_value;
   assign rsp_frame_done  = rsp_word_ff.frame_done;
   assign rsp_outside     = rsp_word_ff.outside;

   // a run never exceeds 128 pixels
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_word_ff.write_count <= COUNT_W'(128))
      else $error("write count above 128");

   // a word without pixels only ever closes a frame
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.write_count == '0)
         |-> (rsp_word_ff.frame_done && !rsp_word_ff.outside))
      else $error("empty write word not marked as frame end");

   // backpressure only when a byte is already staged
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> stage_valid_ff)
      else $error("stall raised with empty input register");

   // a parsed result always reaches the output register
   assert property (@(posedge clock) disable iff (reset)
      (fire && result.has_result) |=> rsp_valid_ff)
      else $error("parsed result lost");

endmodule
